FILE: rtl/rna_pkg.sv
// Package for the register number allocator: item types, codes and sizes.
// No dependencies; used by the interfaces and the top level.
package rna_pkg;

  localparam int POOL_DEPTH = 64;  // numbers per pool, 2..64
  localparam int ARG_LIMIT  = 32;  // argument numbers per counter, 2..63

  localparam int NUM_W  = 6;
  localparam int SIZE_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W  = NUM_W + 1;

  typedef enum logic [3:0] {
    KIND_ALLOC_INT   = 4'd0,
    KIND_ALLOC_FLOAT = 4'd1,
    KIND_FREE        = 4'd2,
    KIND_INT_ARG     = 4'd3,
    KIND_FLOAT_ARG   = 4'd4,
    KIND_ARG_RESET   = 4'd5,
    KIND_INT_RET     = 4'd6,
    KIND_FLOAT_RET   = 4'd7,
    KIND_CLEAR       = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    CLS_INT       = 3'd0,
    CLS_FLOAT     = 3'd1,
    CLS_INT_ARG   = 3'd2,
    CLS_FLOAT_ARG = 3'd3,
    CLS_INT_RET   = 3'd4,
    CLS_FLOAT_RET = 3'd5
  } class_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DOUBLE  = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef logic [POOL_DEPTH-1:0] map_t;
  typedef logic [SIZE_W-1:0]     size_t_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [2:0]       free_class;
    logic [NUM_W-1:0] free_number;
    logic [7:0]       op_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       reg_class;
    logic [NUM_W-1:0] reg_number;
    logic [7:0]       size_out;
    logic [1:0]       status;
  } out_item_t;

endpackage

FILE: rtl/rna_in_if.sv
// Request channel of the register number allocator.
// Depends on rna_pkg for the item type.
interface rna_in_if;
  logic              valid;
  logic              ready;
  rna_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rna_out_if.sv
// Result channel of the register number allocator.
// Depends on rna_pkg for the item type.
interface rna_out_if;
  logic               valid;
  logic               ready;
  rna_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/register_number_allocator.sv
// Register number allocator: two bitmap pools and two argument counters.
// Depends on rna_pkg, rna_in_if and rna_out_if.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+----------------------------------------
//   in_ch     | in  | valid / ready   | kind, free_class, free_number, op_size
//   out_ch    | out | valid / ready   | reg_class, reg_number, size_out, status
//
// One item per cycle sustained unless out_ch stalls; items pass the input
// register, then the result register. The lowest-free search is a single
// priority encoder over the selected pool's map between the two registers.
// Reset empties both pools and counters at once. A stalled result holds the
// result register; the input register fills if empty, then in_ch.ready drops.
module register_number_allocator (
  input  logic     clk,
  input  logic     rst_n,
  rna_in_if.sink   in_ch,
  rna_out_if.source out_ch
);
  import rna_pkg::*;

  // Pipeline control
  logic       s1_v_r;
  in_item_t   s1_r;
  logic       out_v_r;
  out_item_t  out_r;
  logic       adv;
  logic       fire;

  // State
  map_t              int_map_r, int_map_nxt;
  map_t              flt_map_r, flt_map_nxt;
  size_t_t           int_size_r, int_size_nxt;
  size_t_t           flt_size_r, flt_size_nxt;
  logic [NUM_W-1:0]  int_arg_r, int_arg_nxt;
  logic [NUM_W-1:0]  flt_arg_r, flt_arg_nxt;

  // Shared pool datapath
  logic              use_flt;
  map_t              sel_map;
  size_t_t           sel_size;
  logic              found;
  logic [NUM_W-1:0]  low_idx;
  map_t              alloc_map;
  size_t_t           alloc_size;
  logic [NUM_W-1:0]  alloc_num;
  status_t           alloc_st;
  map_t              free_bit;
  logic              free_bad;
  logic              free_dbl;
  out_item_t         res;

  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign fire         = s1_v_r && adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Float pool when allocating float or freeing a float number
  assign use_flt  = (s1_r.kind == KIND_ALLOC_FLOAT) ||
                    (s1_r.kind == KIND_FREE && s1_r.free_class == CLS_FLOAT);
  assign sel_map  = use_flt ? flt_map_r : int_map_r;
  assign sel_size = use_flt ? flt_size_r : int_size_r;

  always_comb begin
    found   = 1'b0;
    low_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (sel_map[i]) begin
        found   = 1'b1;
        low_idx = NUM_W'(i);
      end
    end
  end

  always_comb begin
    alloc_map  = sel_map;
    alloc_size = sel_size;
    alloc_num  = '0;
    alloc_st   = ST_OK;
    if (found) begin
      alloc_map = sel_map & ~(map_t'(1) << low_idx);
      alloc_num = low_idx;
    end else if (sel_size < SIZE_W'(POOL_DEPTH)) begin
      alloc_num  = NUM_W'(sel_size);
      alloc_size = sel_size + SIZE_W'(1);
    end else begin
      alloc_st = ST_FULL;
    end
  end

  assign free_bit = map_t'(1) << s1_r.free_number;
  assign free_bad = CMP_W'(s1_r.free_number) >= CMP_W'(sel_size);
  assign free_dbl = |(sel_map & free_bit);

  always_comb begin
    int_map_nxt  = int_map_r;
    flt_map_nxt  = flt_map_r;
    int_size_nxt = int_size_r;
    flt_size_nxt = flt_size_r;
    int_arg_nxt  = int_arg_r;
    flt_arg_nxt  = flt_arg_r;
    res          = '0;
    case (s1_r.kind)
      KIND_ALLOC_INT: begin
        int_map_nxt  = alloc_map;
        int_size_nxt = alloc_size;
        res = '{CLS_INT, alloc_num, s1_r.op_size, alloc_st};
      end
      KIND_ALLOC_FLOAT: begin
        flt_map_nxt  = alloc_map;
        flt_size_nxt = alloc_size;
        res = '{CLS_FLOAT, alloc_num, s1_r.op_size, alloc_st};
      end
      KIND_FREE: begin
        res.reg_class  = s1_r.free_class;
        res.reg_number = s1_r.free_number;
        if (s1_r.free_class == CLS_INT || s1_r.free_class == CLS_FLOAT) begin
          if (free_bad) begin
            res.status = ST_INVALID;
          end else if (free_dbl) begin
            res.status = ST_DOUBLE;
          end else if (use_flt) begin
            flt_map_nxt = flt_map_r | free_bit;
          end else begin
            int_map_nxt = int_map_r | free_bit;
          end
        end
      end
      KIND_INT_ARG: begin
        res.reg_class = CLS_INT_ARG;
        res.size_out  = s1_r.op_size;
        if (int_arg_r < NUM_W'(ARG_LIMIT)) begin
          res.reg_number = int_arg_r;
          int_arg_nxt    = int_arg_r + NUM_W'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_FLOAT_ARG: begin
        res.reg_class = CLS_FLOAT_ARG;
        res.size_out  = s1_r.op_size;
        if (flt_arg_r < NUM_W'(ARG_LIMIT)) begin
          res.reg_number = flt_arg_r;
          flt_arg_nxt    = flt_arg_r + NUM_W'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_ARG_RESET: begin
        int_arg_nxt = '0;
        flt_arg_nxt = '0;
      end
      KIND_INT_RET: begin
        res.reg_class = CLS_INT_RET;
        res.size_out  = s1_r.op_size;
      end
      KIND_FLOAT_RET: begin
        res.reg_class = CLS_FLOAT_RET;
        res.size_out  = s1_r.op_size;
      end
      KIND_CLEAR: begin
        int_map_nxt  = '0;
        flt_map_nxt  = '0;
        int_size_nxt = '0;
        flt_size_nxt = '0;
        int_arg_nxt  = '0;
        flt_arg_nxt  = '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      int_map_r  <= '0;
      flt_map_r  <= '0;
      int_size_r <= '0;
      flt_size_r <= '0;
      int_arg_r  <= '0;
      flt_arg_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        int_map_r  <= int_map_nxt;
        flt_map_r  <= flt_map_nxt;
        int_size_r <= int_size_nxt;
        flt_size_r <= flt_size_nxt;
        int_arg_r  <= int_arg_nxt;
        flt_arg_r  <= flt_arg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_r <= in_ch.data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  map_t int_live_mask;
  map_t flt_live_mask;
  assign int_live_mask = (map_t'(1) << int_size_r) - map_t'(1);
  assign flt_live_mask = (map_t'(1) << flt_size_r) - map_t'(1);

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int_size_r <= SIZE_W'(POOL_DEPTH) && flt_size_r <= SIZE_W'(POOL_DEPTH))
    else $error("pool size beyond depth");

  a_map_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    (int_map_r & ~int_live_mask) == '0 && (flt_map_r & ~flt_live_mask) == '0)
    else $error("free bit above pool size");

  a_arg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int_arg_r <= NUM_W'(ARG_LIMIT) && flt_arg_r <= NUM_W'(ARG_LIMIT))
    else $error("argument counter beyond limit");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status == ST_FULL |-> out_r.reg_number == '0)
    else $error("full result with nonzero number");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("item lost between input and result register");
`endif

endmodule

FILE: tb/register_number_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench for register_number_allocator: random and directed requests checked
// against an in-bench model of the two pools and argument counters.
// Depends on rna_pkg, rna_in_if, rna_out_if and the RTL top level.
module register_number_allocator_tb;
  import rna_pkg::*;

  typedef struct packed {
    map_t       int_map;
    logic [6:0] int_size;
    map_t       flt_map;
    logic [6:0] flt_size;
    logic [5:0] int_args;
    logic [5:0] flt_args;
  } alloc_state_t;

  logic clk;
  logic rst_n;

  rna_in_if  in_ch ();
  rna_out_if out_ch ();

  register_number_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t     pending_reqs[$];
  out_item_t    results_due[$];
  alloc_state_t issue_state;   // advanced as items are queued
  alloc_state_t accept_state;  // advanced as the DUT accepts items
  logic [5:0]   live_int[$];
  logic [5:0]   live_flt[$];
  int           tx_idle_pct;
  int           rx_stall_pct;
  int           hold_req;
  int           hold_seen;
  int           hold_left;
  int           quiet_cycles;
  bit           failed;
  out_item_t    got_item;
  out_item_t    want_item;

  // ---------------------------------------------------------------- model
  function automatic status_t pool_take(inout map_t map, inout logic [6:0] size,
                                        output logic [5:0] num);
    status_t st;
    st  = ST_FULL;
    num = '0;
    for (int i = 0; i < 64; i++) begin
      if (st == ST_FULL && i < size && map[i]) begin
        map[i] = 1'b0;
        num    = i[5:0];
        st     = ST_OK;
      end
    end
    if (st == ST_FULL && size < POOL_DEPTH) begin
      num  = size[5:0];
      size = size + 7'd1;
      st   = ST_OK;
    end
    return st;
  endfunction

  function automatic status_t pool_give_back(inout map_t map, input logic [6:0] size,
                                             input logic [5:0] num);
    if ({1'b0, num} >= size) return ST_INVALID;
    if (map[num]) return ST_DOUBLE;
    map[num] = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_t arg_take(inout logic [5:0] count, output logic [5:0] num);
    num = '0;
    if (count >= ARG_LIMIT) return ST_FULL;
    num   = count;
    count = count + 6'd1;
    return ST_OK;
  endfunction

  function automatic out_item_t predict_result(inout alloc_state_t s, input in_item_t it);
    out_item_t  r;
    logic [5:0] num;
    r   = '0;
    num = '0;
    case (it.kind)
      KIND_ALLOC_INT: begin
        r.status     = pool_take(s.int_map, s.int_size, num);
        r.reg_class  = CLS_INT;
        r.reg_number = num;
        r.size_out   = it.op_size;
      end
      KIND_ALLOC_FLOAT: begin
        r.status     = pool_take(s.flt_map, s.flt_size, num);
        r.reg_class  = CLS_FLOAT;
        r.reg_number = num;
        r.size_out   = it.op_size;
      end
      KIND_FREE: begin
        case (it.free_class)
          CLS_INT:   r.status = pool_give_back(s.int_map, s.int_size, it.free_number);
          CLS_FLOAT: r.status = pool_give_back(s.flt_map, s.flt_size, it.free_number);
          default:   r.status = ST_OK;  // other classes are not pooled
        endcase
        r.reg_class  = it.free_class;
        r.reg_number = it.free_number;
      end
      KIND_INT_ARG: begin
        r.status     = arg_take(s.int_args, num);
        r.reg_class  = CLS_INT_ARG;
        r.reg_number = num;
        r.size_out   = it.op_size;
      end
      KIND_FLOAT_ARG: begin
        r.status     = arg_take(s.flt_args, num);
        r.reg_class  = CLS_FLOAT_ARG;
        r.reg_number = num;
        r.size_out   = it.op_size;
      end
      KIND_ARG_RESET: begin
        s.int_args = '0;
        s.flt_args = '0;
      end
      KIND_INT_RET: begin
        r.reg_class = CLS_INT_RET;
        r.size_out  = it.op_size;
      end
      KIND_FLOAT_RET: begin
        r.reg_class = CLS_FLOAT_RET;
        r.size_out  = it.op_size;
      end
      KIND_CLEAR: s = '0;
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic logic [7:0] pick_size();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one item and track which numbers are live so frees can target them.
  task automatic push_item(input logic [3:0] kind, input logic [2:0] fcls,
                           input logic [5:0] fnum, input logic [7:0] dsize);
    in_item_t  it;
    out_item_t r;
    it = '{kind: kind, free_class: fcls, free_number: fnum, op_size: dsize};
    pending_reqs.insert(pending_reqs.size(), it);
    r = predict_result(issue_state, it);
    if (r.status == ST_OK) begin
      case (kind)
        KIND_ALLOC_INT:   live_int.insert(live_int.size(), r.reg_number);
        KIND_ALLOC_FLOAT: live_flt.insert(live_flt.size(), r.reg_number);
        KIND_FREE: begin
          if (fcls == CLS_INT) begin
            foreach (live_int[i]) if (live_int[i] == fnum) begin
              live_int.delete(i);
              break;
            end
          end else if (fcls == CLS_FLOAT) begin
            foreach (live_flt[i]) if (live_flt[i] == fnum) begin
              live_flt.delete(i);
              break;
            end
          end
        end
        KIND_CLEAR: begin
          live_int.delete();
          live_flt.delete();
        end
        default: ;
      endcase
    end
  endtask

  task automatic push_live_free();
    bit use_flt;
    use_flt = $urandom_range(1);
    if (use_flt && live_flt.size() > 0)
      push_item(KIND_FREE, CLS_FLOAT, live_flt[$urandom_range(live_flt.size() - 1)],
                8'($urandom));
    else if (live_int.size() > 0)
      push_item(KIND_FREE, CLS_INT, live_int[$urandom_range(live_int.size() - 1)],
                8'($urandom));
    else
      push_item(KIND_ALLOC_INT, 3'($urandom), 6'($urandom), pick_size());
  endtask

  // Fill stretches grow pools and counters toward full; churn stretches mix
  // in frees, resets, clears and junk.
  task automatic push_random(input int count);
    int len;
    bit fill;
    int r;
    while (count > 0) begin
      len  = $urandom_range(40, 300);
      fill = $urandom_range(1);
      for (int n = 0; n < len && count > 0; n++, count--) begin
        r = $urandom_range(99);
        if (fill) begin
          if (r < 25)      push_item(KIND_ALLOC_INT, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 45) push_item(KIND_ALLOC_FLOAT, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 55) push_live_free();
          else if (r < 70) push_item(KIND_INT_ARG, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 85) push_item(KIND_FLOAT_ARG, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 92) push_item(r[0] ? KIND_INT_RET : KIND_FLOAT_RET, 3'($urandom),
                                     6'($urandom), pick_size());
          else             push_item(KIND_FREE, 3'($urandom), 6'($urandom), 8'($urandom));
        end else begin
          if (r < 15)      push_item(KIND_ALLOC_INT, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 30) push_item(KIND_ALLOC_FLOAT, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 55) push_live_free();
          else if (r < 63) push_item(KIND_FREE, 3'($urandom), 6'($urandom), 8'($urandom));
          else if (r < 70) push_item(KIND_INT_ARG, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 77) push_item(KIND_FLOAT_ARG, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 80) push_item(KIND_ARG_RESET, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 85) push_item(r[0] ? KIND_INT_RET : KIND_FLOAT_RET, 3'($urandom),
                                     6'($urandom), pick_size());
          else if (r < 87) push_item(KIND_CLEAR, 3'($urandom), 6'($urandom), pick_size());
          else if (r < 93) push_item(4'($urandom_range(15, 9)), 3'($urandom), 6'($urandom),
                                     8'($urandom));
          else             push_item(4'($urandom), 3'($urandom), 6'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // Sample one step after the edge so the driver's updates have landed.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || in_ch.valid || results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        results_due.insert(results_due.size(), predict_result(accept_state, in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_reqs.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_item = out_ch.data;
        if (results_due.size() == 0) begin
          $error("result with nothing outstanding: class %0d number %0d status %0d",
                 got_item.reg_class, got_item.reg_number, got_item.status);
          failed = 1'b1;
        end else begin
          want_item = results_due.pop_front();
          check_field("reg_class", want_item.reg_class, got_item.reg_class);
          check_field("reg_number", want_item.reg_number, got_item.reg_number);
          check_field("size_out", want_item.size_out, got_item.size_out);
          check_field("status", want_item.status, got_item.status);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen    <= hold_req;
        hold_left    <= 80;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_reqs.size() == 0 && !in_ch.valid && results_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 4000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- sequence
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    tx_idle_pct  = 34;
    rx_stall_pct = 72;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    failed       = 1'b0;
    issue_state  = '0;
    accept_state = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every kind, each corner of the free path
    push_item(KIND_ALLOC_INT, 3'd7, 6'd63, 8'hFF);
    push_item(KIND_ALLOC_INT, 3'd0, 6'd0, 8'h00);
    push_item(KIND_ALLOC_FLOAT, 3'd0, 6'd0, 8'h5A);
    push_item(KIND_FREE, CLS_INT, 6'd0, 8'hFF);     // ok
    push_item(KIND_FREE, CLS_INT, 6'd0, 8'h00);     // double free
    push_item(KIND_FREE, CLS_INT, 6'd63, 8'h00);    // beyond size
    push_item(KIND_FREE, CLS_FLOAT, 6'd1, 8'h00);   // beyond size
    push_item(KIND_FREE, CLS_FLOAT_RET, 6'd63, 8'hA5);
    push_item(KIND_FREE, 3'd7, 6'd42, 8'h00);       // unpooled class
    push_item(KIND_ALLOC_INT, 3'd0, 6'd0, 8'h01);   // reuses freed number
    push_item(KIND_ALLOC_INT, 3'd0, 6'd0, 8'h80);   // appends
    push_item(KIND_INT_ARG, 3'd0, 6'd0, 8'hFF);
    push_item(KIND_FLOAT_ARG, 3'd0, 6'd0, 8'h00);
    push_item(KIND_INT_ARG, 3'd0, 6'd0, 8'h11);
    push_item(KIND_ARG_RESET, 3'd5, 6'd21, 8'hFF);
    push_item(KIND_INT_ARG, 3'd0, 6'd0, 8'h22);
    push_item(KIND_INT_RET, 3'd0, 6'd0, 8'hFF);
    push_item(KIND_FLOAT_RET, 3'd0, 6'd0, 8'hAA);
    push_item(4'd9, 3'd1, 6'd1, 8'h33);
    push_item(4'd15, 3'd7, 6'd63, 8'hFF);
    push_item(KIND_CLEAR, 3'd0, 6'd0, 8'hFF);
    push_item(KIND_FREE, CLS_FLOAT, 6'd0, 8'h00);   // nothing grown after clear
    push_item(KIND_ALLOC_INT, 3'd0, 6'd0, 8'h44);
    wait_drained();

    push_random(700);
    wait_drained();

    tx_idle_pct  = 72;
    rx_stall_pct = 34;
    push_random(700);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    push_random(300);
    wait_drained();
    // long receiver stall while the sender keeps offering: input must back up
    hold_req = hold_req + 1;
    push_random(20);
    push_random(300);
    wait_drained();

    repeat (6) @(posedge clk);
    if (!failed && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rna_pkg.sv
rtl/rna_in_if.sv
rtl/rna_out_if.sv
rtl/register_number_allocator.sv
tb/register_number_allocator_tb.sv
